// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL file that checks itself.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge out of reset
`define AST_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent
`define AST_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/gtc_pkg.sv -----
// Package for the generalized time checker: constants, field slots, snapshot
// and result types, digit push and days-in-month helpers. No dependencies.
package gtc_pkg;

    localparam int unsigned TimeLen   = 15;
    localparam int unsigned PosW      = 5;
    localparam logic [7:0]  Char0     = 8'h30;
    localparam logic [7:0]  Char9     = 8'h39;
    localparam logic [7:0]  CharZ     = 8'h5A;
    localparam logic [6:0]  MonthMax  = 7'd12;
    localparam logic [6:0]  HourMax   = 7'd23;
    localparam logic [6:0]  MinuteMax = 7'd59;
    localparam logic [6:0]  SecondMax = 7'd60;
    localparam logic [6:0]  MonthFeb  = 7'd2;

    localparam logic [PosW-1:0] PosLastDigit = PosW'(TimeLen - 2);
    localparam logic [PosW-1:0] PosZone      = PosW'(TimeLen - 1);
    localparam logic [PosW-1:0] PosMax       = '1;

    // Which value a digit pair feeds (character position divided by two)
    typedef enum logic [2:0] {
        SLOT_CENT   = 3'd0,
        SLOT_YY     = 3'd1,
        SLOT_MONTH  = 3'd2,
        SLOT_DAY    = 3'd3,
        SLOT_HOUR   = 3'd4,
        SLOT_MINUTE = 3'd5,
        SLOT_SECOND = 3'd6
    } t_slot;

    // Accumulated string state as seen by the range checks
    typedef struct packed {
        logic        at_zone;
        logic        bad;
        logic [13:0] year;
        logic [6:0]  cent;
        logic [6:0]  yy;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } t_snap;

    typedef struct packed {
        logic        valid_res;
        logic [13:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
    } t_result;

    function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] s;
        s = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {7'b0, d};
        return s[6:0];
    endfunction

    function automatic logic [13:0] push14(input logic [13:0] acc, input logic [3:0] d);
        logic [17:0] s;
        s = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {14'b0, d};
        return s[13:0];
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic leap);
        logic [4:0] dim;
        unique case (m)
            4'd2:                      dim = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   dim = 5'd30;
            default:                   dim = 5'd31;
        endcase
        return dim;
    endfunction

endpackage

// ----- sv/gtc_in_if.sv -----
// Input channel of the time checker: one character item per handshake.
// Standalone, no package needed.
interface gtc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;

    modport source (output valid, output char_byte, output last_char, input ready);
    modport sink   (input valid, input char_byte, input last_char, output ready);
endinterface

// ----- sv/gtc_out_if.sv -----
// Result channel of the time checker: valid flag and six time fields.
// Standalone, no package needed.
interface gtc_out_if;
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;

    modport source (output valid, output valid_res, output year_out, output month_out,
                    output day_out, output hour_out, output minute_out,
                    output second_out, input ready);
    modport sink   (input valid, input valid_res, input year_out, input month_out,
                    input day_out, input hour_out, input minute_out,
                    input second_out, output ready);
endinterface

// ----- sv/generalized_time_checker_unit.sv -----
// Top level of the generalized time checker: input register, scanner, checker.
// Depends on gtc_pkg, gtc_in_if, gtc_out_if, gtc_scan, gtc_check, assert_macros.svh.
//
//  Channel  Port   Direction  Payload
//  -------  -----  ---------  ---------------------------------------------------
//  chars    i_chr  in         char_byte[7:0], last_char
//  result   o_res  out        valid_res, year/month/day/hour/minute/second_out
//
// One character item is taken per cycle while no last character waits for the result slot.
// After the last character is accepted it passes the input register and then the result
// register, which loads only once the result slot is free; the result is then offered
// until taken. Reset is synchronous and clears the valid flags and the scanner state.
// A stalled result stops only a last-character item in the input register;
// other characters keep flowing while the result waits, up to that last character.
`include "assert_macros.svh"

module generalized_time_checker_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gtc_in_if.sink    i_chr,
    gtc_out_if.source o_res
);
    import gtc_pkg::*;

    logic       r_in_vld;
    logic [7:0] r_chr;
    logic       r_last;

    logic  adv;
    logic  out_free;
    t_snap snap;

    logic  res_zero;
    logic  res_in_range;

    // Move the held item on; a last character also needs a free result slot
    assign adv         = r_in_vld && (!r_last || out_free);
    assign i_chr.ready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_chr.ready) begin
            r_in_vld <= i_chr.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_chr.valid && i_chr.ready) begin
            r_chr  <= i_chr.char_byte;
            r_last <= i_chr.last_char;
        end
    end

    gtc_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_char  (r_chr),
        .i_last  (r_last),
        .o_snap  (snap)
    );

    gtc_check u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && r_last),
        .i_snap  (snap),
        .o_free  (out_free),
        .o_res   (o_res)
    );

    // Summaries of the offered result for the checks below
    assign res_zero     = (o_res.year_out == 14'd0) && (o_res.month_out == 4'd0) &&
                          (o_res.day_out == 5'd0) && (o_res.hour_out == 5'd0) &&
                          (o_res.minute_out == 6'd0) && (o_res.second_out == 6'd0);
    assign res_in_range = (o_res.month_out != 4'd0) && (o_res.month_out <= 4'd12) &&
                          (o_res.day_out != 5'd0) && (o_res.hour_out <= 5'd23) &&
                          (o_res.minute_out <= 6'd59) && (o_res.second_out <= 6'd60);

    // Failed strings carry all-zero fields
    `AST_SAME(a_zero_on_fail, o_res.valid && !o_res.valid_res, res_zero, "invalid result with nonzero fields")
    // Passed strings stay within their ranges
    `AST_SAME(a_range_on_pass, o_res.valid && o_res.valid_res, res_in_range, "valid result out of range")
    // Empty input register always takes an item
    `AST_ALWAYS(a_ready_when_empty, r_in_vld || i_chr.ready, "input stalled while empty")
    // A non-last character never waits on the result side
    `AST_NEXT(a_char_flows, r_in_vld && !r_last && !(i_chr.valid && i_chr.ready), !r_in_vld, "character held without cause")

endmodule

// ----- sv/gtc_scan.sv -----
// Character scanner: position counter, format flag and digit accumulators.
// Depends on gtc_pkg.
module gtc_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_char,
    input  logic          i_last,
    output gtc_pkg::t_snap o_snap
);
    import gtc_pkg::*;

    logic [PosW-1:0] r_pos, n_pos;
    logic            r_bad, n_bad;
    logic [13:0]     r_year, n_year;
    logic [6:0]      r_cent, n_cent;
    logic [6:0]      r_yy, n_yy;
    logic [6:0]      r_month, n_month;
    logic [6:0]      r_day, n_day;
    logic [6:0]      r_hour, n_hour;
    logic [6:0]      r_minute, n_minute;
    logic [6:0]      r_second, n_second;

    logic       is_digit;
    logic       in_digits;
    logic       char_bad;
    logic [3:0] dig;
    t_slot      slot;

    // Classify the character against its position
    always_comb begin
        is_digit  = (i_char >= Char0) && (i_char <= Char9);
        in_digits = (r_pos <= PosLastDigit);
        dig       = i_char[3:0];
        slot      = t_slot'(r_pos[3:1]);
        if (in_digits) begin
            char_bad = !is_digit;
        end else if (r_pos == PosZone) begin
            char_bad = (i_char != CharZ);
        end else begin
            char_bad = 1'b1;
        end
    end

    // Advance the state on each item, clear it after the last one
    always_comb begin
        n_pos    = r_pos;
        n_bad    = r_bad;
        n_year   = r_year;
        n_cent   = r_cent;
        n_yy     = r_yy;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        if (i_fire) begin
            if (i_last) begin
                n_pos    = '0;
                n_bad    = 1'b0;
                n_year   = '0;
                n_cent   = '0;
                n_yy     = '0;
                n_month  = '0;
                n_day    = '0;
                n_hour   = '0;
                n_minute = '0;
                n_second = '0;
            end else begin
                n_bad = r_bad | char_bad;
                if (r_pos != PosMax) begin
                    n_pos = r_pos + 1'b1;
                end
                if (in_digits && is_digit) begin
                    case (slot)
                        SLOT_CENT: begin
                            n_year = push14(r_year, dig);
                            n_cent = push7(r_cent, dig);
                        end
                        SLOT_YY: begin
                            n_year = push14(r_year, dig);
                            n_yy   = push7(r_yy, dig);
                        end
                        SLOT_MONTH:  n_month  = push7(r_month, dig);
                        SLOT_DAY:    n_day    = push7(r_day, dig);
                        SLOT_HOUR:   n_hour   = push7(r_hour, dig);
                        SLOT_MINUTE: n_minute = push7(r_minute, dig);
                        SLOT_SECOND: n_second = push7(r_second, dig);
                        default:     n_second = r_second;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_bad    <= 1'b0;
            r_year   <= '0;
            r_cent   <= '0;
            r_yy     <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
        end else begin
            r_pos    <= n_pos;
            r_bad    <= n_bad;
            r_year   <= n_year;
            r_cent   <= n_cent;
            r_yy     <= n_yy;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
        end
    end

    // Present the state plus this character's format verdict
    always_comb begin
        o_snap.at_zone = (r_pos == PosZone);
        o_snap.bad     = r_bad | char_bad;
        o_snap.year    = r_year;
        o_snap.cent    = r_cent;
        o_snap.yy      = r_yy;
        o_snap.month   = r_month;
        o_snap.day     = r_day;
        o_snap.hour    = r_hour;
        o_snap.minute  = r_minute;
        o_snap.second  = r_second;
    end

endmodule

// ----- sv/gtc_check.sv -----
// Range checks on a finished string and the result register.
// Depends on gtc_pkg and gtc_out_if.
module gtc_check (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  gtc_pkg::t_snap i_snap,
    output logic           o_free,
    gtc_out_if.source      o_res
);
    import gtc_pkg::*;

    logic    r_vld;
    t_result r_res;
    t_result n_res;

    logic       leap;
    logic       month_ok;
    logic [4:0] dim;
    logic       day_ok;
    logic       ok;

    // Leap year from the digit pairs: century and year of century
    always_comb begin
        leap     = (i_snap.yy[1:0] == 2'b00) &&
                   ((i_snap.yy != 7'd0) || (i_snap.cent[1:0] == 2'b00));
        month_ok = (i_snap.month != 7'd0) && (i_snap.month <= MonthMax);
        dim      = days_in_month(i_snap.month[3:0], leap);
        day_ok   = (i_snap.day != 7'd0) && (i_snap.day <= {2'b0, dim});
        ok       = i_snap.at_zone && !i_snap.bad && month_ok && day_ok &&
                   (i_snap.hour <= HourMax) && (i_snap.minute <= MinuteMax) &&
                   (i_snap.second <= SecondMax);
    end

    // Pass the fields of a good string through, zero every field of a failed one
    always_comb begin
        if (ok) begin
            n_res.valid_res  = 1'b1;
            n_res.year_out   = i_snap.year;
            n_res.month_out  = i_snap.month[3:0];
            n_res.day_out    = i_snap.day[4:0];
            n_res.hour_out   = i_snap.hour[4:0];
            n_res.minute_out = i_snap.minute[5:0];
            n_res.second_out = i_snap.second[5:0];
        end else begin
            n_res = '0;
        end
    end

    assign o_free = !r_vld || o_res.ready;

    // Hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid      = r_vld;
    assign o_res.valid_res  = r_res.valid_res;
    assign o_res.year_out   = r_res.year_out;
    assign o_res.month_out  = r_res.month_out;
    assign o_res.day_out    = r_res.day_out;
    assign o_res.hour_out   = r_res.hour_out;
    assign o_res.minute_out = r_res.minute_out;
    assign o_res.second_out = r_res.second_out;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for generalized_time_checker_unit: streams time strings
// through the character channel and checks each verdict against an own model.
// Depends on gtc_pkg, gtc_in_if, gtc_out_if and the RTL of the checker.
`timescale 1ns / 1ps

module testbench;

    import gtc_pkg::*;

    localparam int unsigned RandomChars = 1950;
    localparam int unsigned CycleLimit  = 200000;
    localparam int unsigned ReportMax   = 10;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       last_char;
    } char_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    gtc_in_if  chr_if ();
    gtc_out_if res_if ();

    generalized_time_checker_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr_if),
        .o_res   (res_if)
    );

    always #4 i_clk = ~i_clk;

    // Characters waiting to be sent, and verdicts waiting to come back
    char_item_t  char_queue[$];
    logic [7:0]  str_buf[$];
    t_result     time_verdicts[$];
    int unsigned chars_queued = 0;
    int unsigned time_errors = 0;
    int unsigned cycle_count = 0;
    bit          chr_taken = 1'b0;

    // Own copy of the string scanner state
    logic [PosW-1:0] scan_pos = '0;
    logic            scan_bad = 1'b0;
    logic [13:0]     acc_year = '0;
    logic [6:0]      acc_month = '0;
    logic [6:0]      acc_day = '0;
    logic [6:0]      acc_hour = '0;
    logic [6:0]      acc_minute = '0;
    logic [6:0]      acc_second = '0;

    // Gregorian month length; out-of-range months fall to 31
    function automatic int unsigned month_length(input int unsigned m, input int unsigned y);
        bit leap;
        leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
        if (m == MonthFeb) return leap ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // Advance the scanner by one character; return 1 with the verdict on the last one
    function automatic bit scan_time_char(input char_item_t it, output t_result verdict);
        logic [PosW-1:0] p;
        logic [3:0]      d;
        bit              ok;
        p = scan_pos;
        verdict = '0;
        if (p <= PosLastDigit) begin
            if (it.char_byte < Char0 || it.char_byte > Char9) begin
                scan_bad = 1'b1;
            end else begin
                d = 4'(it.char_byte - Char0);
                case (t_slot'(3'(p >> 1)))
                    SLOT_CENT, SLOT_YY: acc_year   = 14'(acc_year * 10 + d);
                    SLOT_MONTH:         acc_month  = 7'(acc_month * 10 + d);
                    SLOT_DAY:           acc_day    = 7'(acc_day * 10 + d);
                    SLOT_HOUR:          acc_hour   = 7'(acc_hour * 10 + d);
                    SLOT_MINUTE:        acc_minute = 7'(acc_minute * 10 + d);
                    default:            acc_second = 7'(acc_second * 10 + d);
                endcase
            end
        end else if (p == PosZone) begin
            if (it.char_byte != CharZ) scan_bad = 1'b1;
        end else begin
            scan_bad = 1'b1;
        end
        if (scan_pos != PosMax) scan_pos = scan_pos + 1'b1;
        if (!it.last_char) return 1'b0;

        ok = (p == PosZone) && !scan_bad
             && acc_month >= 1 && acc_month <= MonthMax
             && acc_day >= 1 && acc_day <= month_length(acc_month, acc_year)
             && acc_hour <= HourMax && acc_minute <= MinuteMax
             && acc_second <= SecondMax;
        if (ok) begin
            verdict.valid_res  = 1'b1;
            verdict.year_out   = acc_year;
            verdict.month_out  = acc_month[3:0];
            verdict.day_out    = acc_day[4:0];
            verdict.hour_out   = acc_hour[4:0];
            verdict.minute_out = acc_minute[5:0];
            verdict.second_out = acc_second[5:0];
        end
        scan_pos   = '0;
        scan_bad   = 1'b0;
        acc_year   = '0;
        acc_month  = '0;
        acc_day    = '0;
        acc_hour   = '0;
        acc_minute = '0;
        acc_second = '0;
        return 1'b1;
    endfunction

    // Append a number as a fixed count of decimal digits
    task automatic push_num(input int unsigned v, input int unsigned digits);
        for (int i = digits; i > 0; i--) begin
            str_buf.push_back(8'(Char0 + (v / (10 ** (i - 1))) % 10));
        end
    endtask

    task automatic push_random_bytes(input int unsigned n);
        repeat (n) str_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Move the built string to the send queue, marking its final character
    task automatic commit_string();
        foreach (str_buf[i]) begin
            char_queue.push_back('{char_byte: str_buf[i],
                                   last_char: logic'(i == str_buf.size() - 1)});
        end
        chars_queued += str_buf.size();
        str_buf.delete();
    endtask

    // Stimulus: directed strings, then random time strings and broken ones
    initial begin
        int unsigned y, m, d, h, mi, s, kind, dim, target;

        chr_if.valid     = 1'b0;
        chr_if.char_byte = '0;
        chr_if.last_char = 1'b0;
        res_if.ready     = 1'b0;

        // Largest legal values with a leap second
        push_num(9999, 4); push_num(12, 2); push_num(31, 2);
        push_num(23, 2); push_num(59, 2); push_num(60, 2);
        str_buf.push_back(CharZ);
        commit_string();
        // One-character strings: all-zero byte, all-ones byte, lone zone mark
        str_buf.push_back(8'h00); commit_string();
        str_buf.push_back(8'hFF); commit_string();
        str_buf.push_back(CharZ); commit_string();

        target = chars_queued + RandomChars;
        while (chars_queued < target) begin
            case ($urandom_range(0, 4))
                0: y = $urandom_range(0, 9999);
                1: y = $urandom_range(0, 99) * 100;
                2: y = $urandom_range(0, 24) * 400;
                3: y = $urandom_range(0, 2499) * 4;
                default: y = $urandom_range(0, 1) ? 9999 : 0;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: m = $urandom_range(1, 12);
                7: m = MonthFeb;
                8: m = $urandom_range(0, 1) ? 13 : 0;
                default: m = $urandom_range(0, 99);
            endcase
            dim = month_length(m, y);
            case ($urandom_range(0, 9))
                0, 1, 2: d = $urandom_range(1, dim);
                3: d = dim;
                4: d = dim + 1;
                5: d = 0;
                6: d = $urandom_range(0, 99);
                default: d = $urandom_range(1, 28);
            endcase
            case ($urandom_range(0, 5))
                0: h = $urandom_range(23, 24);
                1: h = $urandom_range(0, 99);
                default: h = $urandom_range(0, 23);
            endcase
            case ($urandom_range(0, 5))
                0: mi = $urandom_range(59, 60);
                1: mi = $urandom_range(0, 99);
                default: mi = $urandom_range(0, 59);
            endcase
            case ($urandom_range(0, 5))
                0: s = $urandom_range(59, 61);
                1: s = $urandom_range(0, 99);
                default: s = $urandom_range(0, 59);
            endcase
            push_num(y, 4); push_num(m, 2); push_num(d, 2);
            push_num(h, 2); push_num(mi, 2); push_num(s, 2);
            str_buf.push_back(CharZ);

            // Corrupt a share of the strings
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                // keep well formed
            end else if (kind < 72) begin
                str_buf[TimeLen - 1] = 8'($urandom_range(0, 255));
            end else if (kind < 80) begin
                case ($urandom_range(0, 2))
                    0: str_buf[$urandom_range(0, TimeLen - 2)] = Char0 - 8'd1;
                    1: str_buf[$urandom_range(0, TimeLen - 2)] = Char9 + 8'd1;
                    default: str_buf[$urandom_range(0, TimeLen - 2)] =
                                 8'($urandom_range(0, 255));
                endcase
            end else if (kind < 88) begin
                d = $urandom_range(1, TimeLen - 1);
                while (str_buf.size() > d) void'(str_buf.pop_back());
            end else if (kind < 94) begin
                push_random_bytes($urandom_range(1, 25));
            end else begin
                str_buf.delete();
                push_random_bytes($urandom_range(1, 20));
            end
            commit_string();
        end

        // Release reset at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Drain, then allow the result pipeline to settle
        while (char_queue.size() != 0 || chr_if.valid || time_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);

        if (time_errors == 0 && time_verdicts.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Sender: bursts of characters separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        logic       nv;
        logic [7:0] nc;
        logic       nl;
        char_item_t it;
        nv = chr_if.valid;
        nc = chr_if.char_byte;
        nl = chr_if.last_char;
        if (i_rst_n) begin
            if (nv && chr_taken) nv = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (char_queue.size() > 0) begin
                    it = char_queue.pop_front();
                    nv = 1'b1;
                    nc = it.char_byte;
                    nl = it.last_char;
                    if (burst_left == 0) burst_left = $urandom_range(1, 40);
                    burst_left--;
                    if (burst_left == 0) begin
                        case ($urandom_range(0, 7))
                            0, 1: gap_left = 0;
                            7:    gap_left = $urandom_range(7, 20);
                            default: gap_left = $urandom_range(1, 6);
                        endcase
                    end
                end
            end
        end
        chr_if.valid     <= nv;
        chr_if.char_byte <= nc;
        chr_if.last_char <= nl;
    end

    // Receiver: stall pattern chosen anew each time the 8-bit rdy_count wraps
    logic [7:0]  rdy_count = '0;
    int unsigned rdy_mode = 0;
    int unsigned hold_left = 0;

    always @(negedge i_clk) begin
        logic nr;
        if (rdy_count == 0) rdy_mode = $urandom_range(0, 3);
        case (rdy_mode)
            0: nr = 1'b1;
            1: nr = ($urandom_range(0, 9) < 7);
            2: nr = (rdy_count[3:0] >= 4'd5);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    nr = res_if.ready;
                end else begin
                    nr = !res_if.ready;
                    hold_left = nr ? $urandom_range(0, 10) : $urandom_range(0, 20);
                end
            end
        endcase
        rdy_count <= rdy_count + 8'd1;
        res_if.ready <= nr;
    end

    // Monitor: predict on accepted characters, check accepted verdicts
    always @(posedge i_clk) begin
        char_item_t it;
        t_result    want;
        t_result    got;
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("FAILURE");
            $finish;
        end else begin
            chr_taken = i_rst_n && chr_if.valid && chr_if.ready;
            if (chr_taken) begin
                it.char_byte = chr_if.char_byte;
                it.last_char = chr_if.last_char;
                if (scan_time_char(it, want)) time_verdicts.push_back(want);
            end
            if (i_rst_n && res_if.valid && res_if.ready) begin
                got.valid_res  = res_if.valid_res;
                got.year_out   = res_if.year_out;
                got.month_out  = res_if.month_out;
                got.day_out    = res_if.day_out;
                got.hour_out   = res_if.hour_out;
                got.minute_out = res_if.minute_out;
                got.second_out = res_if.second_out;
                if (time_verdicts.size() == 0) begin
                    time_errors++;
                    if (time_errors <= ReportMax) begin
                        $display("[%0t] unexpected time result: %p", $realtime, got);
                    end
                end else begin
                    want = time_verdicts.pop_front();
                    if (got.valid_res !== want.valid_res || got.year_out !== want.year_out
                        || got.month_out !== want.month_out || got.day_out !== want.day_out
                        || got.hour_out !== want.hour_out
                        || got.minute_out !== want.minute_out
                        || got.second_out !== want.second_out) begin
                        time_errors++;
                        if (time_errors <= ReportMax) begin
                            $display("[%0t] time result mismatch: expected %p, got %p",
                                     $realtime, want, got);
                        end
                    end
                end
            end
        end
    end

endmodule
